// File: hw/rtl/integer_polynomial_arith_unit_top_defines.svh
// assertion macros for the integer polynomial arithmetic unit
// used by integer_polynomial_arith_unit_top; needs i_clk and i_rst_n in scope
`ifndef INTEGER_POLYNOMIAL_ARITH_UNIT_TOP_DEFINES_SVH
`define INTEGER_POLYNOMIAL_ARITH_UNIT_TOP_DEFINES_SVH

// same-cycle implication under reset
`define IPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define IPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/intpa_pkg.sv
// shared types and constants for the integer polynomial arithmetic unit
// no dependencies
package intpa_pkg;

    localparam int MAX_DEGREE = 31;
    localparam int COEF_W     = 32;
    localparam int DEG_W      = 5;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_A  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_B  = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_DIV0,
        ST_INEXACT
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_AS_RD,
        S_AS_EMIT,
        S_MUL_INIT,
        S_MUL_RD,
        S_MUL_MUL,
        S_MUL_ACC,
        S_MUL_EMIT,
        S_DIV_LEAD,
        S_DIV_CHK,
        S_CP_RD,
        S_CP_WR,
        S_DV_RD,
        S_DV_START,
        S_DV_WAIT,
        S_SUB_RD,
        S_SUB_MUL,
        S_SUB_WR,
        S_Q_RD,
        S_Q_EMIT,
        S_ZERO
    } t_state;

endpackage

// File: hw/rtl/intpa_div.sv
// iterative signed divider, one quotient bit per cycle, truncating
// depends on intpa_pkg
module intpa_div
    import intpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [COEF_W-1:0] i_num,
    input  logic [COEF_W-1:0] i_den,
    output logic              o_done,
    output logic              o_inexact,
    output logic [COEF_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(COEF_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [COEF_W-1:0] r_q;
    logic [COEF_W-1:0] r_den;
    logic [COEF_W-1:0] r_rem;
    logic              r_neg;
    logic [COEF_W:0]   w_shift;
    logic [COEF_W:0]   w_diff;

    assign w_shift = {r_rem, r_q[COEF_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(COEF_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitudes in, restoring steps on the magnitude
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[COEF_W-1] ? (COEF_W'(0) - i_num) : i_num;
            r_den <= i_den[COEF_W-1] ? (COEF_W'(0) - i_den) : i_den;
            r_rem <= '0;
            r_neg <= i_num[COEF_W-1] ^ i_den[COEF_W-1];
        end else if (r_busy) begin
            if (!w_diff[COEF_W]) begin
                r_rem <= w_diff[COEF_W-1:0];
                r_q   <= {r_q[COEF_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[COEF_W-1:0];
                r_q   <= {r_q[COEF_W-2:0], 1'b0};
            end
        end
    end

    assign o_done    = r_done;
    assign o_inexact = (r_rem != '0);
    assign o_quot    = r_neg ? (COEF_W'(0) - r_q) : r_q;

endmodule

// File: hw/rtl/integer_polynomial_arith_unit_top.sv
// integer polynomial arithmetic unit: add, subtract, multiply, exact divide
// depends on intpa_pkg, intpa_div and integer_polynomial_arith_unit_top_defines.svh
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata coef_index, coef_value; tuser kind;
//                                                tlast final_load
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata out_index, out_value; tuser status;
//                                                tlast out_last
// cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index, i_cfg_data
//
// loads are taken while idle; the word with tlast starts a compute burst and tready
// stays low until the last result word has entered the output register
// add/sub: read both coefficients, then emit each word; multiply: read, multiply and
// accumulate each product term, then emit each word; divide: copy the dividend, then
// per quotient coefficient run the shared 1-bit-per-cycle divider and subtract the
// product from the shared multiplier, then emit each word; a stalled output
// holds the sequencer; reset is synchronous, active low, and clears control,
// config and valid; datapath registers and coefficient stores hold garbage until written
`include "integer_polynomial_arith_unit_top_defines.svh"

module integer_polynomial_arith_unit_top
    import intpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // loads
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,  // coef_index[4:0], coef_value[36:5], zero pad
    input  logic                 s_axis_tuser,  // kind
    input  logic                 s_axis_tlast,  // final_load
    // results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata,  // out_index[5:0], out_value[37:6], zero pad
    output logic [1:0]           m_axis_tuser,  // status
    output logic                 m_axis_tlast,  // out_last
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEG_W-1:0]     i_cfg_data
);

    // coefficient stores, remainder scratch and quotient buffer
    logic [COEF_W-1:0] mem_a [MAX_DEGREE+1];
    logic [COEF_W-1:0] mem_b [MAX_DEGREE+1];
    logic [COEF_W-1:0] mem_r [MAX_DEGREE+1];
    logic [COEF_W-1:0] mem_q [MAX_DEGREE+1];

    t_state            r_state, n_state;
    t_op               r_op;
    logic [DEG_W-1:0]  r_da, r_db;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [DEG_W-1:0]  r_i, n_i;
    logic [DEG_W-1:0]  r_l, n_l;
    logic [COEF_W-1:0] r_acc, n_acc;
    logic [COEF_W-1:0] r_prod, n_prod;
    logic [COEF_W-1:0] r_lead, n_lead;
    logic [COEF_W-1:0] r_quot, n_quot;
    t_status           r_status, n_status;

    logic [COEF_W-1:0] r_a_rd, r_b_rd, r_r_rd, r_q_rd;
    logic              a_re, b_re, r_re, q_re;
    logic [DEG_W-1:0]  a_ra, b_ra, r_ra, q_ra;
    logic              r_we, q_we;
    logic [DEG_W-1:0]  r_wa, q_wa;
    logic [COEF_W-1:0] r_wd;

    // output register
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_out_index;
    logic [COEF_W-1:0] r_out_value;
    t_status           r_out_status;
    logic              r_out_last;
    logic              emit;
    logic [IDX_W-1:0]  emit_index;
    logic [COEF_W-1:0] emit_value;
    logic              emit_last;
    logic              out_slot;

    logic              div_start;
    logic              div_done;
    logic              div_inexact;
    logic [COEF_W-1:0] div_quot;

    logic              load_acc;
    logic [DEG_W-1:0]  ld_idx;
    logic [COEF_W-1:0] ld_val;

    logic [DEG_W-1:0]  deg_as;
    logic [IDX_W-1:0]  deg_mul;
    logic [DEG_W-1:0]  deg_div;
    logic [DEG_W-1:0]  mul_lo, mul_hi;
    logic [DEG_W-1:0]  base;
    logic [COEF_W-1:0] as_a, as_b;
    logic [COEF_W-1:0] mul_out;

    assign ld_idx   = s_axis_tdata[4:0];
    assign ld_val   = s_axis_tdata[36:5];
    assign load_acc = s_axis_tvalid && s_axis_tready;

    assign deg_as  = (r_da > r_db) ? r_da : r_db;
    assign deg_mul = IDX_W'(r_da) + IDX_W'(r_db);
    assign deg_div = r_da - r_db;
    // product terms a[i]*b[k-i] with i in [lo, hi]
    assign mul_lo  = (r_k > IDX_W'(r_db)) ? DEG_W'(r_k - IDX_W'(r_db)) : '0;
    assign mul_hi  = (r_k < IDX_W'(r_da)) ? r_k[DEG_W-1:0] : r_da;
    assign base    = r_i - r_db;
    assign as_a    = (r_k <= IDX_W'(r_da)) ? r_a_rd : '0;
    assign as_b    = (r_k <= IDX_W'(r_db)) ? r_b_rd : '0;

    // shared multiplier, low word only
    assign mul_out = (r_state == S_SUB_MUL) ? (r_quot * r_b_rd) : (r_a_rd * r_b_rd);

    assign out_slot = !r_out_valid || m_axis_tready;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_ADD;
            r_da <= '0;
            r_db <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OPERATION: r_op <= t_op'(i_cfg_data[1:0]);
                CFG_DEGREE_A:  r_da <= i_cfg_data;
                CFG_DEGREE_B:  r_db <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (load_acc && !s_axis_tuser) mem_a[ld_idx] <= ld_val;
        if (load_acc && s_axis_tuser)  mem_b[ld_idx] <= ld_val;
        if (r_we) mem_r[r_wa] <= r_wd;
        if (q_we) mem_q[q_wa] <= div_quot;
        if (a_re) r_a_rd <= mem_a[a_ra];
        if (b_re) r_b_rd <= mem_b[b_ra];
        if (r_re) r_r_rd <= mem_r[r_ra];
        if (q_re) r_q_rd <= mem_q[q_ra];
    end

    intpa_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_num     (r_r_rd),
        .i_den     (r_lead),
        .o_done    (div_done),
        .o_inexact (div_inexact),
        .o_quot    (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_i      <= '0;
            r_l      <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_i      <= n_i;
            r_l      <= n_l;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_lead <= n_lead;
        r_quot <= n_quot;
    end

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_k           = r_k;
        n_i           = r_i;
        n_l           = r_l;
        n_acc         = r_acc;
        n_prod        = r_prod;
        n_lead        = r_lead;
        n_quot        = r_quot;
        n_status      = r_status;
        s_axis_tready = 1'b0;
        a_re = 1'b0; a_ra = r_i;
        b_re = 1'b0; b_ra = r_i;
        r_re = 1'b0; r_ra = r_i;
        q_re = 1'b0; q_ra = r_k[DEG_W-1:0];
        r_we = 1'b0; r_wa = r_i; r_wd = r_a_rd;
        q_we = 1'b0; q_wa = base;
        div_start  = 1'b0;
        emit       = 1'b0;
        emit_index = r_k;
        emit_value = r_acc;
        emit_last  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (load_acc && s_axis_tlast) begin
                    n_k      = '0;
                    n_status = ST_OK;
                    unique case (r_op)
                        OP_ADD, OP_SUB: n_state = S_AS_RD;
                        OP_MUL:         n_state = S_MUL_INIT;
                        default:        n_state = S_DIV_LEAD;
                    endcase
                end
            end
            S_AS_RD: begin
                a_re = 1'b1; a_ra = r_k[DEG_W-1:0];
                b_re = 1'b1; b_ra = r_k[DEG_W-1:0];
                n_state = S_AS_EMIT;
            end
            S_AS_EMIT: begin
                emit_value = (r_op == OP_ADD) ? (as_a + as_b) : (as_a - as_b);
                emit_last  = (r_k == IDX_W'(deg_as));
                if (out_slot) begin
                    emit = 1'b1;
                    if (emit_last) n_state = S_IDLE;
                    else begin
                        n_k = r_k + 1'b1;
                        n_state = S_AS_RD;
                    end
                end
            end
            S_MUL_INIT: begin
                n_acc   = '0;
                n_i     = mul_lo;
                n_state = S_MUL_RD;
            end
            S_MUL_RD: begin
                a_re = 1'b1; a_ra = r_i;
                b_re = 1'b1; b_ra = DEG_W'(r_k - IDX_W'(r_i));
                n_state = S_MUL_MUL;
            end
            S_MUL_MUL: begin
                n_prod  = mul_out;
                n_state = S_MUL_ACC;
            end
            S_MUL_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_i == mul_hi) n_state = S_MUL_EMIT;
                else begin
                    n_i = r_i + 1'b1;
                    n_state = S_MUL_RD;
                end
            end
            S_MUL_EMIT: begin
                emit_last = (r_k == deg_mul);
                if (out_slot) begin
                    emit = 1'b1;
                    if (emit_last) n_state = S_IDLE;
                    else begin
                        n_k = r_k + 1'b1;
                        n_state = S_MUL_INIT;
                    end
                end
            end
            S_DIV_LEAD: begin
                b_re = 1'b1; b_ra = r_db;
                n_state = S_DIV_CHK;
            end
            S_DIV_CHK: begin
                n_lead = r_b_rd;
                n_i    = '0;
                if (r_b_rd == '0) begin
                    n_status = ST_DIV0;
                    n_state  = S_ZERO;
                end else if (r_da < r_db) begin
                    n_state = S_ZERO;
                end else begin
                    n_state = S_CP_RD;
                end
            end
            S_CP_RD: begin
                a_re = 1'b1; a_ra = r_i;
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                r_we = 1'b1; r_wa = r_i; r_wd = r_a_rd;
                if (r_i == r_da) n_state = S_DV_RD;
                else begin
                    n_i = r_i + 1'b1;
                    n_state = S_CP_RD;
                end
            end
            S_DV_RD: begin
                r_re = 1'b1; r_ra = r_i;
                n_state = S_DV_START;
            end
            S_DV_START: begin
                div_start = 1'b1;
                n_state = S_DV_WAIT;
            end
            S_DV_WAIT: begin
                if (div_done) begin
                    if (div_inexact) begin
                        n_status = ST_INEXACT;
                        n_state  = S_ZERO;
                    end else begin
                        q_we    = 1'b1;
                        n_quot  = div_quot;
                        n_l     = '0;
                        n_state = S_SUB_RD;
                    end
                end
            end
            S_SUB_RD: begin
                r_re = 1'b1; r_ra = base + r_l;
                b_re = 1'b1; b_ra = r_l;
                n_state = S_SUB_MUL;
            end
            S_SUB_MUL: begin
                n_prod  = mul_out;
                n_state = S_SUB_WR;
            end
            S_SUB_WR: begin
                r_we = 1'b1; r_wa = base + r_l; r_wd = r_r_rd - r_prod;
                if (r_l == r_db) begin
                    if (r_i == r_db) begin
                        n_k = '0;
                        n_state = S_Q_RD;
                    end else begin
                        n_i = r_i - 1'b1;
                        n_state = S_DV_RD;
                    end
                end else begin
                    n_l = r_l + 1'b1;
                    n_state = S_SUB_RD;
                end
            end
            S_Q_RD: begin
                q_re = 1'b1; q_ra = r_k[DEG_W-1:0];
                n_state = S_Q_EMIT;
            end
            S_Q_EMIT: begin
                emit_value = r_q_rd;
                emit_last  = (r_k == IDX_W'(deg_div));
                if (out_slot) begin
                    emit = 1'b1;
                    if (emit_last) n_state = S_IDLE;
                    else begin
                        n_k = r_k + 1'b1;
                        n_state = S_Q_RD;
                    end
                end
            end
            S_ZERO: begin
                emit_index = '0;
                emit_value = '0;
                emit_last  = 1'b1;
                if (out_slot) begin
                    emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register, refilled in the cycle the word leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_index  <= emit_index;
            r_out_value  <= emit_value;
            r_out_status <= r_status;
            r_out_last   <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_value, r_out_index};
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    // a final load always starts a burst
    `IPA_ASSERT_NXT(a_final_starts, load_acc && s_axis_tlast, !s_axis_tready, "final load did not start compute")
    // the last word of a burst returns the sequencer to idle
    `IPA_ASSERT_NXT(a_last_idle, emit && emit_last, r_state == S_IDLE, "sequencer busy after last word")
    // a divide-by-zero result is the single zero coefficient
    `IPA_ASSERT_IMP(a_div0_zero, m_axis_tvalid && (m_axis_tuser == ST_DIV0), m_axis_tlast && (m_axis_tdata == '0), "bad divide-by-zero word")
    // the divider only runs inside the division phase
    `IPA_ASSERT_IMP(a_div_scope, div_start, r_op == OP_DIV, "divider started outside division")

endmodule
